### hw/rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the chunked body decoder: parse phases,
// failure codes, framing characters and the decoder state record.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

    localparam int LINE_CAP_DEFAULT = 128;

    // Largest size that may still take one more hex digit without overflow.
    localparam logic [31:0] SIZE_LIMIT = 32'h0FFF_FFFF;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Failure codes as reported on fail_code.
    localparam logic [2:0] FC_NONE   = 3'd0;
    localparam logic [2:0] FC_CR     = 3'd1;
    localparam logic [2:0] FC_LONG   = 3'd2;
    localparam logic [2:0] FC_NODIG  = 3'd3;
    localparam logic [2:0] FC_OVF    = 3'd4;
    localparam logic [2:0] FC_SUFFIX = 3'd5;
    localparam logic [2:0] FC_TERM   = 3'd6;

    typedef enum logic [8:0] {
        PH_SIZE     = 9'b0_0000_0001,
        PH_SIZE_CR  = 9'b0_0000_0010,
        PH_DATA     = 9'b0_0000_0100,
        PH_DEND     = 9'b0_0000_1000,
        PH_DEND_CR  = 9'b0_0001_0000,
        PH_TRAIL    = 9'b0_0010_0000,
        PH_TRAIL_CR = 9'b0_0100_0000,
        PH_DONE     = 9'b0_1000_0000,
        PH_FAIL     = 9'b1_0000_0000
    } phase_t;

    // Decoder state apart from the line length, whose width follows LINE_CAP.
    typedef struct packed {
        phase_t      phase;
        logic [31:0] size_accum;
        logic        digits_seen;
        logic        in_hex_run;
        logic [31:0] chunk_remaining;
        logic [31:0] body_count;
        logic [2:0]  error_latch;
        logic        unterminated_flag;
    } dec_state_t;

    // One result transaction.
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       body_complete;
        logic       unterminated;
        logic       failed;
        logic [2:0] fail_code;
        logic       ignored;
    } dec_result_t;

endpackage

`default_nettype wire

### hw/rtl/hcbd_step.sv
// ----------------------------------------------------------------------------
// hcbd_step
// Next-state and result logic for one body byte of the chunked decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_step #(
    parameter int LINE_CAP = hcbd_pkg::LINE_CAP_DEFAULT,
    localparam int LEN_W   = $clog2(LINE_CAP)
) (
    input  wire hcbd_pkg::dec_state_t  cur,
    input  wire logic [LEN_W-1:0]      len_cur,
    input  wire logic [7:0]            in_byte,
    input  wire logic [31:0]           expected_length,
    output hcbd_pkg::dec_state_t       nxt,
    output logic [LEN_W-1:0]           len_next,
    output hcbd_pkg::dec_result_t      res
);

    logic             hex_ok;
    logic [3:0]       hex_val;
    logic             len_full;
    logic             size_end;
    logic             trail_end;
    logic             data_byte_seen;
    logic             ign;
    logic [2:0]       pend;
    logic [31:0]      count_inc;
    logic [31:0]      remain_dec;
    logic [LEN_W:0]   len_plus;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            hex_val = 4'(in_byte - 8'h30);
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
            hex_val = 4'(in_byte - 8'h57);
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
            hex_val = 4'(in_byte - 8'h37);
        else
            hex_ok = 1'b0;
    end

    assign len_plus   = {1'b0, len_cur} + (LEN_W+1)'(1);
    assign len_full   = len_plus >= (LEN_W+1)'(LINE_CAP);
    assign count_inc  = (cur.body_count != hcbd_pkg::COUNT_MAX) ?
                        cur.body_count + 32'd1 : cur.body_count;
    assign remain_dec = (cur.chunk_remaining != 32'd0) ?
                        cur.chunk_remaining - 32'd1 : cur.chunk_remaining;

    always_comb
    begin
        nxt            = cur;
        len_next       = len_cur;
        size_end       = 1'b0;
        trail_end      = 1'b0;
        data_byte_seen = 1'b0;
        ign            = 1'b0;
        pend           = cur.error_latch;

        unique case (cur.phase)
            hcbd_pkg::PH_SIZE:
            begin
                if (in_byte == hcbd_pkg::CH_CR)
                    nxt.phase = hcbd_pkg::PH_SIZE_CR;
                else if (in_byte == hcbd_pkg::CH_LF)
                    size_end = 1'b1;
                else if (len_full)
                begin
                    nxt.error_latch = hcbd_pkg::FC_LONG;
                    nxt.phase       = hcbd_pkg::PH_FAIL;
                end
                else
                begin
                    len_next = len_plus[LEN_W-1:0];
                    if (cur.in_hex_run)
                    begin
                        if (hex_ok)
                        begin
                            // Once the size is too big for another digit, the
                            // rest of the line is only counted.
                            if (cur.size_accum > hcbd_pkg::SIZE_LIMIT)
                            begin
                                nxt.error_latch = hcbd_pkg::FC_OVF;
                                nxt.in_hex_run  = 1'b0;
                            end
                            else
                            begin
                                nxt.size_accum  = {cur.size_accum[27:0], hex_val};
                                nxt.digits_seen = 1'b1;
                            end
                        end
                        else
                        begin
                            nxt.in_hex_run = 1'b0;
                            if (!cur.digits_seen)
                                nxt.error_latch = hcbd_pkg::FC_NODIG;
                            else if (in_byte != hcbd_pkg::CH_SEMI &&
                                     in_byte != hcbd_pkg::CH_SPACE &&
                                     in_byte != hcbd_pkg::CH_TAB)
                                nxt.error_latch = hcbd_pkg::FC_SUFFIX;
                        end
                    end
                end
            end
            hcbd_pkg::PH_SIZE_CR:
            begin
                if (in_byte == hcbd_pkg::CH_LF)
                    size_end = 1'b1;
                else
                begin
                    nxt.error_latch = hcbd_pkg::FC_CR;
                    nxt.phase       = hcbd_pkg::PH_FAIL;
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                data_byte_seen      = 1'b1;
                nxt.chunk_remaining = remain_dec;
                nxt.body_count      = count_inc;
                if (remain_dec == 32'd0)
                begin
                    if (expected_length != 32'd0 && count_inc >= expected_length)
                    begin
                        nxt.unterminated_flag = 1'b1;
                        nxt.phase             = hcbd_pkg::PH_DONE;
                    end
                    else
                        nxt.phase = hcbd_pkg::PH_DEND;
                end
            end
            hcbd_pkg::PH_DEND, hcbd_pkg::PH_DEND_CR:
            begin
                if (in_byte == hcbd_pkg::CH_LF)
                begin
                    nxt.size_accum  = 32'd0;
                    nxt.digits_seen = 1'b0;
                    nxt.in_hex_run  = 1'b1;
                    nxt.error_latch = hcbd_pkg::FC_NONE;
                    len_next        = '0;
                    nxt.phase       = hcbd_pkg::PH_SIZE;
                end
                else if (in_byte == hcbd_pkg::CH_CR && cur.phase == hcbd_pkg::PH_DEND)
                    nxt.phase = hcbd_pkg::PH_DEND_CR;
                else
                begin
                    nxt.error_latch = hcbd_pkg::FC_TERM;
                    nxt.phase       = hcbd_pkg::PH_FAIL;
                end
            end
            hcbd_pkg::PH_TRAIL:
            begin
                if (in_byte == hcbd_pkg::CH_CR)
                    nxt.phase = hcbd_pkg::PH_TRAIL_CR;
                else if (in_byte == hcbd_pkg::CH_LF)
                    trail_end = 1'b1;
                else if (len_full)
                begin
                    nxt.error_latch = hcbd_pkg::FC_LONG;
                    nxt.phase       = hcbd_pkg::PH_FAIL;
                end
                else
                    len_next = len_plus[LEN_W-1:0];
            end
            hcbd_pkg::PH_TRAIL_CR:
            begin
                if (in_byte == hcbd_pkg::CH_LF)
                begin
                    nxt.phase = hcbd_pkg::PH_TRAIL;
                    trail_end = 1'b1;
                end
                else
                begin
                    nxt.error_latch = hcbd_pkg::FC_CR;
                    nxt.phase       = hcbd_pkg::PH_FAIL;
                end
            end
            default:
                ign = 1'b1;
        endcase

        // End of a size line: a pending parse failure takes effect here.
        if (size_end)
        begin
            if (pend == hcbd_pkg::FC_NONE && !cur.digits_seen)
                pend = hcbd_pkg::FC_NODIG;
            if (pend != hcbd_pkg::FC_NONE)
            begin
                nxt.error_latch = pend;
                nxt.phase       = hcbd_pkg::PH_FAIL;
            end
            else if (cur.size_accum == 32'd0)
            begin
                len_next  = '0;
                nxt.phase = hcbd_pkg::PH_TRAIL;
            end
            else
            begin
                nxt.chunk_remaining = cur.size_accum;
                nxt.phase           = hcbd_pkg::PH_DATA;
            end
        end

        // An empty trailer line closes the body.
        if (trail_end)
        begin
            if (len_cur == '0)
                nxt.phase = hcbd_pkg::PH_DONE;
            else
                len_next = '0;
        end
    end

    always_comb
    begin
        res.data_valid    = data_byte_seen;
        res.data_byte     = data_byte_seen ? in_byte : 8'd0;
        res.body_complete = nxt.phase == hcbd_pkg::PH_DONE;
        res.unterminated  = (nxt.phase == hcbd_pkg::PH_DONE) && nxt.unterminated_flag;
        res.failed        = nxt.phase == hcbd_pkg::PH_FAIL;
        res.fail_code     = (nxt.phase == hcbd_pkg::PH_FAIL) ? nxt.error_latch :
                            hcbd_pkg::FC_NONE;
        res.ignored       = ign;
    end

endmodule

`default_nettype wire

### hw/rtl/http_chunked_body_decoder_unit.sv
// A byte accepted into the input register moves on to the result register,
// which drives m_tvalid, as soon as that register is free to take it.
// Throughput: one byte per cycle while the receiver keeps taking results.
// Reset: rst_n clears the parse state, the expected length and both valid
// flags at once; the block accepts bytes as soon as reset is released.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Chunked transfer body decoder: parses chunk-size lines, passes payload
// bytes through, checks data terminators and trailer lines.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder_unit #(
    parameter int LINE_CAP = hcbd_pkg::LINE_CAP_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration: expected_length, written whenever cfg_wr_en is high.
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    // Input stream. s_tdata: in_byte[7:0].
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    // Output stream. m_tuser: data_valid.
    // m_tdata: data_byte[7:0], body_complete[8], unterminated[9], failed[10],
    // fail_code[13:11], ignored[14], zero[15].
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tuser
);

    localparam int LEN_W = $clog2(LINE_CAP);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    hcbd_pkg::dec_result_t  out_reg;
    hcbd_pkg::dec_result_t  res_next;
    hcbd_pkg::dec_state_t   state_reg;
    hcbd_pkg::dec_state_t   state_next;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic [31:0]            expected_length_reg;
    logic                   advance;

    // The held byte moves into the result register whenever that register is
    // empty or its transaction completes in this cycle. The input register
    // refills in the same cycle, so a full pipeline keeps one byte per cycle
    // flowing; a stalled output halts the input once the input register fills.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    hcbd_step #(
        .LINE_CAP (LINE_CAP)
    ) u_step (
        .cur             (state_reg),
        .len_cur         (len_reg),
        .in_byte         (in_byte_reg),
        .expected_length (expected_length_reg),
        .nxt             (state_next),
        .len_next        (len_next),
        .res             (res_next)
    );

    // Control state and parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg                  <= 1'b0;
            out_valid_reg                 <= 1'b0;
            expected_length_reg           <= 32'd0;
            len_reg                       <= '0;
            state_reg.phase               <= hcbd_pkg::PH_SIZE;
            state_reg.size_accum          <= 32'd0;
            state_reg.digits_seen         <= 1'b0;
            state_reg.in_hex_run          <= 1'b1;
            state_reg.chunk_remaining     <= 32'd0;
            state_reg.body_count          <= 32'd0;
            state_reg.error_latch         <= hcbd_pkg::FC_NONE;
            state_reg.unterminated_flag   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                expected_length_reg <= cfg_wr_data;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                state_reg <= state_next;
                len_reg   <= len_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
        if (advance)
            out_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.data_valid;
    assign m_tdata  = {1'b0, out_reg.ignored, out_reg.fail_code, out_reg.failed,
                       out_reg.unterminated, out_reg.body_complete, out_reg.data_byte};

endmodule

`default_nettype wire

### hw/rtl/hcbd_checker.sv
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks of the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser
);

    // A failure always carries a code, and a code appears only with a failure.
    a_fail_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10] == (m_tdata[13:11] != 3'd0)))
        else $error("fail_code does not agree with failed");

    // Completion and failure exclude each other; unterminated needs completion.
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[8] && m_tdata[10]) && (!m_tdata[9] || m_tdata[8]))
        else $error("inconsistent completion flags");

    // A payload byte is never reported as ignored or failed; idle bytes read zero.
    a_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser ? (!m_tdata[14] && !m_tdata[10]) : (m_tdata[7:0] == 8'd0)))
        else $error("payload flag inconsistent with result");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for http_chunked_body_decoder_unit
// Feeds one chunked body through the decoder with bursty input and a
// stalling receiver, predicts every result transaction byte by byte and
// compares each field as it comes out. The run ends with one randomly chosen
// closing: a zero chunk with trailers, the expected length, or a framing fault.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import hcbd_pkg::*;

// Tracks the decoder state and holds the results that are still to come out.
class chunk_decode_scoreboard;
    logic [31:0] expected_length;
    phase_t      phase;
    logic [31:0] size_accum;
    bit          digits_seen;
    bit          in_hex_run;
    int unsigned line_length;
    logic [31:0] chunk_remaining;
    logic [31:0] body_count;
    logic [2:0]  error_latch;
    bit          unterminated_flag;

    dec_result_t pending_results[$];
    int          errors;
    int          checked;

    function new();
        expected_length   = '0;
        phase             = PH_SIZE;
        chunk_remaining   = '0;
        body_count        = '0;
        unterminated_flag = 1'b0;
        errors            = 0;
        checked           = 0;
        start_line();
    endfunction

    function void start_line();
        size_accum  = '0;
        digits_seen = 1'b0;
        in_hex_run  = 1'b1;
        line_length = 0;
        error_latch = FC_NONE;
    endfunction

    function void fail_with(logic [2:0] code);
        error_latch = code;
        phase       = PH_FAIL;
    endfunction

    // Counts one content byte of a line; false when the line grew too long.
    function bit count_content();
        if (line_length + 1 >= LINE_CAP_DEFAULT)
        begin
            fail_with(FC_LONG);
            return 1'b0;
        end
        line_length++;
        return 1'b1;
    endfunction

    function void close_size_line();
        logic [2:0] pend;
        pend = error_latch;
        if (pend == FC_NONE && !digits_seen)
            pend = FC_NODIG;
        if (pend != FC_NONE)
        begin
            fail_with(pend);
            return;
        end
        if (size_accum == 0)
        begin
            line_length = 0;
            phase       = PH_TRAIL;
        end
        else
        begin
            chunk_remaining = size_accum;
            phase           = PH_DATA;
        end
    endfunction

    function void close_trailer_line();
        if (line_length == 0)
            phase = PH_DONE;
        else
            line_length = 0;
    endfunction

    // Advances the state by one accepted byte and queues the result it causes.
    function void note_byte(logic [7:0] c);
        dec_result_t r;
        int          digit;
        r = '0;
        case (phase)
            PH_SIZE:
            begin
                if (c == CH_CR)
                    phase = PH_SIZE_CR;
                else if (c == CH_LF)
                    close_size_line();
                else if (count_content() && in_hex_run)
                begin
                    digit = -1;
                    if (c >= "0" && c <= "9")
                        digit = int'(c - "0");
                    else if (c >= "a" && c <= "f")
                        digit = int'(c - "a") + 10;
                    else if (c >= "A" && c <= "F")
                        digit = int'(c - "A") + 10;
                    if (digit >= 0)
                    begin
                        if (size_accum > SIZE_LIMIT)
                        begin
                            error_latch = FC_OVF;
                            in_hex_run  = 1'b0;
                        end
                        else
                        begin
                            size_accum  = {size_accum[27:0], digit[3:0]};
                            digits_seen = 1'b1;
                        end
                    end
                    else
                    begin
                        in_hex_run = 1'b0;
                        if (!digits_seen)
                            error_latch = FC_NODIG;
                        else if (c != CH_SEMI && c != CH_SPACE && c != CH_TAB)
                            error_latch = FC_SUFFIX;
                    end
                end
            end
            PH_SIZE_CR:
            begin
                if (c == CH_LF)
                    close_size_line();
                else
                    fail_with(FC_CR);
            end
            PH_DATA:
            begin
                r.data_valid = 1'b1;
                r.data_byte  = c;
                if (chunk_remaining != 0)
                    chunk_remaining--;
                if (body_count != COUNT_MAX)
                    body_count++;
                if (chunk_remaining == 0)
                begin
                    if (expected_length != 0 && body_count >= expected_length)
                    begin
                        unterminated_flag = 1'b1;
                        phase             = PH_DONE;
                    end
                    else
                        phase = PH_DEND;
                end
            end
            PH_DEND:
            begin
                if (c == CH_CR)
                    phase = PH_DEND_CR;
                else if (c == CH_LF)
                begin
                    start_line();
                    phase = PH_SIZE;
                end
                else
                    fail_with(FC_TERM);
            end
            PH_DEND_CR:
            begin
                if (c == CH_LF)
                begin
                    start_line();
                    phase = PH_SIZE;
                end
                else
                    fail_with(FC_TERM);
            end
            PH_TRAIL:
            begin
                if (c == CH_CR)
                    phase = PH_TRAIL_CR;
                else if (c == CH_LF)
                    close_trailer_line();
                else
                    void'(count_content());
            end
            PH_TRAIL_CR:
            begin
                if (c == CH_LF)
                begin
                    phase = PH_TRAIL;
                    close_trailer_line();
                end
                else
                    fail_with(FC_CR);
            end
            default:
                r.ignored = 1'b1;
        endcase
        r.body_complete = (phase == PH_DONE);
        r.unterminated  = (phase == PH_DONE) && unterminated_flag;
        r.failed        = (phase == PH_FAIL);
        r.fail_code     = (phase == PH_FAIL) ? error_latch : FC_NONE;
        pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    // Compares one result transaction against the oldest prediction.
    function void check_result(logic user, logic [15:0] data);
        dec_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("Result with no byte pending: tuser %0h, tdata %0h", user, data);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        checked++;
        compare_field("data_valid", 8'(want.data_valid), 8'(user));
        compare_field("data_byte", want.data_byte, data[7:0]);
        compare_field("body_complete", 8'(want.body_complete), 8'(data[8]));
        compare_field("unterminated", 8'(want.unterminated), 8'(data[9]));
        compare_field("failed", 8'(want.failed), 8'(data[10]));
        compare_field("fail_code", 8'(want.fail_code), 8'(data[13:11]));
        compare_field("ignored", 8'(want.ignored), 8'(data[14]));
    endfunction
endclass

module testbench;

    // Payload bytes to offer before the body gets its closing.
    localparam int RANDOM_BYTES    = 520;
    // Cycles to let pass once the last result is in.
    localparam int IDLE_SETTLE     = 6;
    // The long receiver hold-off starts after this many results.
    localparam int HOLD_OFF_AFTER  = 150;
    localparam int HOLD_OFF_CYCLES = 90;
    // Cycles without any transaction that count as a hang. The longest
    // legal quiet stretch is the hold-off plus one sender gap.
    localparam int WATCHDOG_LIMIT  = 4000;

    // Ways in which the body is brought to an end.
    typedef enum int {
        END_ZERO_CHUNK,
        END_LENGTH_REACHED,
        END_SIZE_STRAY_CR,
        END_LINE_TOO_LONG,
        END_NO_DIGITS,
        END_SIZE_OVERFLOW,
        END_BAD_SUFFIX,
        END_BAD_TERMINATOR,
        END_TRAILER_STRAY_CR
    } body_end_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    chunk_decode_scoreboard sb = new();

    // Sender bookkeeping.
    int        burst_left    = 0;
    int        bytes_sent    = 0;
    int        chunks_sent   = 0;
    int        length_writes = 0;
    bit        hold_taken    = 1'b0;
    body_end_t body_end;

    http_chunked_body_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Both streams are watched at the clock edge, where every handshake
    // signal still shows the value it had during the cycle that just ended.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
        end
    end

    // Offers one byte and returns at the edge where the transaction took
    // place, or after a gap when it ends a burst; bytes go out in bursts.
    // Some bursts are long, so that the block also sees unbroken streams.
    task automatic send_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Lines may end with CR LF or with a bare LF.
    task automatic send_eol();
        if ($urandom_range(0, 1))
            send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // Any byte that does not end a line.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    // Writes a chunk-size line: optional leading zeros, the hex digits in
    // random letter case, and an optional extension. With fill_line set the
    // extension stretches the line to the longest length still allowed.
    task automatic send_size_line(input logic [31:0] size, input int pad,
                                  input int ext_len, input bit fill_line);
        int         ndig;
        int         i;
        logic [3:0] nib;
        logic [7:0] sep;
        ndig = 1;
        while (ndig < 8 && (size >> (4 * ndig)) != 0)
            ndig++;
        if (fill_line)
            ext_len = LINE_CAP_DEFAULT - 1 - ndig - pad;
        repeat (pad) send_byte("0");
        for (i = ndig - 1; i >= 0; i--)
        begin
            nib = size[4 * i +: 4];
            if (nib < 10)
                send_byte("0" + nib);
            else
                send_byte(8'(($urandom_range(0, 1) ? "a" : "A") + nib - 10));
        end
        if (ext_len > 0)
        begin
            case ($urandom_range(0, 2))
                0:       sep = CH_SEMI;
                1:       sep = CH_SPACE;
                default: sep = CH_TAB;
            endcase
            send_byte(sep);
            repeat (ext_len - 1) send_byte(text_byte());
        end
        send_eol();
    endtask

    // One whole chunk: size line, payload of any byte values, terminator.
    task automatic send_chunk(input int n, input int pad, input int ext_len,
                              input bit fill_line);
        send_size_line(n, pad, ext_len, fill_line);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        send_eol();
        chunks_sent++;
    endtask

    // Stops offering bytes and waits until the block has delivered all
    // outstanding results and its pipeline has drained.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // Called only while the block is idle.
    task automatic write_expected_length(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.expected_length = value;
        length_writes++;
    endtask

    // Receiver: mostly ready, sometimes toggling, sometimes stalled. Once,
    // well into the run, it holds off long enough for the block to fill up
    // and push back on the sender.
    initial
    begin
        int span;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!hold_taken && sb.checked >= HOLD_OFF_AFTER)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_taken = 1'b1;
            end
            else
            begin
                span = $urandom_range(1, 30);
                case ($urandom_range(0, 3))
                    0, 1:
                    begin
                        m_tready <= 1'b1;
                        repeat (span) @(posedge clk);
                    end
                    2:
                    begin
                        repeat (span)
                        begin
                            m_tready <= 1'($urandom_range(0, 1));
                            @(posedge clk);
                        end
                    end
                    default:
                    begin
                        m_tready <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge clk);
                    end
                endcase
            end
        end
    end

    // Watchdog: any cycle with a transaction on either side restarts the count.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout after %0d quiet cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Main sequence. The decoder latches completion and failure until reset,
    // and reset is applied only once, so the whole run is one long body that
    // ends with a single closing picked at random.
    initial
    begin
        int  n;
        bit  mid_written;
        mid_written = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_expected_length(32'd0);

        // Directed opening: single-digit size with a CR LF terminator and a
        // zero payload byte; a ';' extension with CR, LF and 0xFF carried as
        // payload; a leading zero with a space extension; a tab extension
        // with bare LF endings.
        send_text("1\r\n");
        send_byte(8'h00);
        send_text("\r\n");
        send_text("3;e\n");
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("\n");
        send_text("02 \n");
        send_byte(8'h80);
        send_byte(8'h7F);
        send_text("\r\n");
        send_text("1\t\n");
        send_byte(8'h55);
        send_text("\n");
        chunks_sent += 4;

        // The largest announced length is never reached by this body.
        wait_idle();
        write_expected_length(32'hFFFF_FFFF);

        // Random well-formed chunks: mostly small, some larger, with random
        // leading zeros, extensions and now and then a size line of the
        // greatest length the decoder accepts.
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (!mid_written && bytes_sent >= RANDOM_BYTES / 2)
            begin
                wait_idle();
                write_expected_length(sb.body_count + 32'h0010_0000
                                      + $urandom_range(0, 32'h00FF_FFFF));
                mid_written = 1'b1;
            end
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_chunk(n,
                       ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0,
                       ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : 0,
                       ($urandom_range(0, 19) == 0));
        end

        body_end = body_end_t'($urandom_range(0, 8));
        case (body_end)
            END_ZERO_CHUNK:
            begin
                send_size_line(32'd0, $urandom_range(0, 2),
                               ($urandom_range(0, 1) ? $urandom_range(1, 20) : 0), 1'b0);
                repeat ($urandom_range(0, 3))
                begin
                    repeat ($urandom_range(1, 40)) send_byte(text_byte());
                    send_eol();
                end
                send_eol();
            end
            END_LENGTH_REACHED:
            begin
                // The body stops at the last payload byte of this chunk.
                n = $urandom_range(1, 8);
                wait_idle();
                write_expected_length(sb.body_count + $urandom_range(1, n));
                send_size_line(n, 0, 0, 1'b0);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            END_SIZE_STRAY_CR:
                send_text("5\rX");
            END_LINE_TOO_LONG:
            begin
                // Either in a size line or in a trailer line.
                if ($urandom_range(0, 1))
                    send_text("0\r\n");
                repeat (LINE_CAP_DEFAULT) send_byte(text_byte());
            end
            END_NO_DIGITS:
            begin
                if ($urandom_range(0, 1))
                    send_eol();
                else
                    send_text(";ext\n");
            end
            END_SIZE_OVERFLOW:
                send_text("123456789\r\n");
            END_BAD_SUFFIX:
                send_text("5x\n");
            END_BAD_TERMINATOR:
            begin
                send_text("2\n");
                repeat (2) send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                    send_byte(CH_CR);
                send_byte("Z");
            end
            default:
                send_text("0\r\nab\rX");
        endcase

        // Bytes after the end must all come back marked as ignored.
        repeat (8) send_byte(8'($urandom_range(0, 255)));

        wait_idle();

        $display("Covered %0d chunks and %0d bytes, %0d results checked, closing %s.",
                 chunks_sent, bytes_sent, sb.checked, body_end.name());
        $display("Expected length written %0d times; long receiver hold-off taken: %0d.",
                 length_writes, hold_taken);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
